// File: src/lbp_pkg.sv
// Shared types and constants for the LSB-first bit packer.
`timescale 1ns / 1ps
`default_nettype none
package lbp_pkg;

  // Widest value that one pack item may append
  localparam int VALUE_WIDTH = 32;
  localparam int BYTE_W      = 8;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 6;
  // Held bits plus one full value
  localparam int ACC_W       = DATA_W + BYTE_W;
  localparam int HELD_W      = 3;

  // Byte job handed from front to back
  localparam int JOB_BYTES   = 4;
  localparam int JCNT_W      = 3;

  // Job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input tdata layout
  localparam int S_TDATA_W   = 40;

  typedef enum logic {
    OP_PACK  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic [JOB_BYTES*BYTE_W-1:0] data;
    logic [JCNT_W-1:0]           nbytes;
  } job_t;

endpackage
`default_nettype wire

// File: src/lsb_first_bit_packer_top.sv
// An item's bytes pass through the job queue and then the output byte register.
// Throughput: one output byte per cycle while m_tready is high; an item yields zero to
// four bytes, which leave through the single output byte register.
// Items are taken every cycle while the two-entry job queue has room.
// Reset (rst, synchronous): clears the held partial byte, the queue and the output.
// Top level of the LSB-first variable-width bit packer.
`timescale 1ns / 1ps
`default_nettype none
module lsb_first_bit_packer_top
  import lbp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] data_value, [37:32] req_count
  input  wire logic                 s_tuser,  // [0] operation
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [BYTE_W-1:0]         m_tdata,  // [7:0] out_byte
  output logic                      m_tlast   // [0] last
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  lbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  lbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  lbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// File: src/lbp_front.sv
// Front end: accepts pack and flush items, keeps the partial byte, builds byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module lbp_front
  import lbp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // [31:0] data_value, [37:32] req_count
  input  wire logic               s_tuser,    // [0] operation
  input  wire logic               q_full,
  output logic                    q_push,
  output job_t                    q_job
);

  logic [BYTE_W-1:0]  partial_byte;
  logic [HELD_W-1:0]  partial_bits;
  logic [BYTE_W-1:0]  partial_byte_next;
  logic [HELD_W-1:0]  partial_bits_next;

  logic               accept;
  op_t                op;
  logic [DATA_W-1:0]  data_value;
  logic [COUNT_W-1:0] req_count;
  logic [COUNT_W-1:0] cnt_sat;
  logic [DATA_W-1:0]  value_masked;
  logic [ACC_W-1:0]   combined;
  logic [ACC_W-1:0]   rest;
  logic [COUNT_W-1:0] total;
  logic [JCNT_W-1:0]  nbytes;

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign op         = op_t'(s_tuser);
  assign data_value = s_tdata[DATA_W-1:0];
  assign req_count  = s_tdata[DATA_W+COUNT_W-1:DATA_W];

  // Saturate the count, drop value bits above it, place above the held bits
  always_comb begin
    cnt_sat      = (req_count > COUNT_W'(VALUE_WIDTH)) ? COUNT_W'(VALUE_WIDTH) : req_count;
    value_masked = data_value & ~({DATA_W{1'b1}} << cnt_sat);
    combined     = ({{BYTE_W{1'b0}}, value_masked} << partial_bits)
                 | {{DATA_W{1'b0}}, partial_byte};
    total        = {{(COUNT_W-HELD_W){1'b0}}, partial_bits} + cnt_sat;
    nbytes       = total[COUNT_W-1:HELD_W];
    rest         = combined >> {nbytes, {HELD_W{1'b0}}};
  end

  // Classify the item: job to queue and new partial state
  always_comb begin
    q_push            = 1'b0;
    q_job.data        = combined[JOB_BYTES*BYTE_W-1:0];
    q_job.nbytes      = nbytes;
    partial_byte_next = partial_byte;
    partial_bits_next = partial_bits;
    if (accept) begin
      case (op)
        OP_FLUSH: begin
          q_push            = (partial_bits != '0);
          q_job.data        = {{((JOB_BYTES-1)*BYTE_W){1'b0}}, partial_byte};
          q_job.nbytes      = JCNT_W'(1);
          partial_byte_next = '0;
          partial_bits_next = '0;
        end
        OP_PACK: begin
          q_push            = (nbytes != '0);
          partial_byte_next = rest[BYTE_W-1:0];
          partial_bits_next = total[HELD_W-1:0];
        end
        default: begin
          q_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= '0;
      partial_bits <= '0;
    end else begin
      partial_byte <= partial_byte_next;
      partial_bits <= partial_bits_next;
    end
  end

endmodule
`default_nettype wire

// File: src/lbp_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module lbp_queue
  import lbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      full,
  output logic      empty
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_job = mem[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/lbp_back.sv
// Back end: drains byte jobs one byte per cycle into the output register while it is free.
`timescale 1ns / 1ps
`default_nettype none
module lbp_back
  import lbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire job_t              q_head,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
  output logic                   m_tlast    // [0] last
);

  logic [JOB_BYTES*BYTE_W-1:0] cur;
  logic [JCNT_W-1:0]           rem;
  logic                        busy;
  logic                        out_free;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = out_free && !busy && !q_empty;

  // Emit the next byte of the current job, or start the job at the queue head
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rem      <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (out_free) begin
      if (busy) begin
        m_tvalid <= 1'b1;
        m_tdata  <= cur[BYTE_W-1:0];
        m_tlast  <= (rem == JCNT_W'(1));
        cur      <= cur >> BYTE_W;
        rem      <= rem - 1'b1;
        busy     <= (rem != JCNT_W'(1));
      end else if (!q_empty) begin
        m_tvalid <= 1'b1;
        m_tdata  <= q_head.data[BYTE_W-1:0];
        m_tlast  <= (q_head.nbytes == JCNT_W'(1));
        cur      <= q_head.data >> BYTE_W;
        rem      <= q_head.nbytes - 1'b1;
        busy     <= (q_head.nbytes != JCNT_W'(1));
      end else begin
        m_tvalid <= 1'b0;
        m_tlast  <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // An active job always has bytes left, fewer than a full job
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem != '0) && (rem < JCNT_W'(JOB_BYTES)))
    else $error("lbp_back: bad remaining byte count");

  // The final byte of a running job is marked
  assert property (@(posedge clk) disable iff (rst)
    (out_free && busy && rem == JCNT_W'(1)) |=> (m_tvalid && m_tlast && !busy))
    else $error("lbp_back: final byte not marked");

  // No job is taken from the queue while another is still running
  assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_pop)
    else $error("lbp_back: queue popped during a job");
`endif

endmodule
`default_nettype wire
